### design/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, codes and constants of the dead reckoning smoother.
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 12;

	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int SPEED_W = 24;
	localparam int SNAP_W  = 20;
	localparam int HOR_W   = 8;
	localparam int BLEND_W = 9;
	localparam int IVL_W   = 11;
	localparam int TICK_W  = 8;
	localparam int REV_W   = 16;

	// Item command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_PLACE = 2'd0,
		CMD_RECV  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} item_cmd_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_DISTANCE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HORIZON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_FACTOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_INTERVAL = 3'd4;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 24'd4096;
	localparam logic [SNAP_W-1:0]  SNAP_DIST_RST  = 20'd16384;
	localparam logic [HOR_W-1:0]   MAX_HOR_RST    = 8'd8;
	localparam logic [BLEND_W-1:0] BLEND_RST      = 9'd128;
	localparam logic [IVL_W-1:0]   START_IVL_RST  = 11'd256;

	// Datapath micro-operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PLACE,
		OP_SNAP,
		OP_SNAP_SS,
		OP_RECV_COMMIT,
		OP_TICK_PRE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_VEL_COMMIT,
		OP_REVERT,
		OP_AIM_MUL,
		OP_AIM_ADD,
		OP_SNAP_APPLY,
		OP_BLEND_MUL,
		OP_BLEND_ACC,
		OP_BLEND_FIN,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic       sel_tick;
	} dp_cmd_t;

	typedef struct packed {
		item_cmd_t item_cmd;
		logic      teleport;
		logic      updated;
		logic      snap_res;
		logic      div_done;
	} dp_stat_t;

endpackage

### design/drs_ctrl.sv
// ----------------------------------------------------------------------------
// drs_ctrl
// Sequencer that walks the datapath through place, receive and tick items.
// ----------------------------------------------------------------------------
module drs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output drs_pkg::dp_cmd_t  cmd,
	input  drs_pkg::dp_stat_t stat
);
	import drs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_R_SNAP,
		ST_R_SS,
		ST_R_COMMIT,
		ST_T_PRE,
		ST_T_DIVINIT,
		ST_T_DIV,
		ST_T_VEL,
		ST_T_REV,
		ST_T_AIM_MUL,
		ST_T_AIM_ADD,
		ST_T_SNAP,
		ST_T_SS,
		ST_T_DECIDE,
		ST_T_BMUL,
		ST_T_BACC,
		ST_T_BFIN,
		ST_RESULT
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic       out_valid_q;
	logic       res_go;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign res_go    = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.axis     = axis_q;
		cmd.sel_tick = 1'b0;
		cmd.op       = OP_NONE;
		unique case (state_q)
			ST_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_DISPATCH:  cmd.op = (stat.item_cmd == CMD_PLACE) ? OP_PLACE : OP_NONE;
			ST_R_SNAP:    cmd.op = OP_SNAP;
			ST_R_SS:      cmd.op = OP_SNAP_SS;
			ST_R_COMMIT:  cmd.op = OP_RECV_COMMIT;
			ST_T_PRE:     cmd.op = OP_TICK_PRE;
			ST_T_DIVINIT: cmd.op = OP_DIV_INIT;
			ST_T_DIV:     cmd.op = stat.div_done ? OP_NONE : OP_DIV_STEP;
			ST_T_VEL:     cmd.op = OP_VEL_COMMIT;
			ST_T_REV:     cmd.op = OP_REVERT;
			ST_T_AIM_MUL: cmd.op = OP_AIM_MUL;
			ST_T_AIM_ADD: cmd.op = OP_AIM_ADD;
			ST_T_SNAP: begin
				cmd.op       = OP_SNAP;
				cmd.sel_tick = 1'b1;
			end
			ST_T_SS:      cmd.op = OP_SNAP_SS;
			ST_T_DECIDE:  cmd.op = OP_SNAP_APPLY;
			ST_T_BMUL:    cmd.op = OP_BLEND_MUL;
			ST_T_BACC:    cmd.op = OP_BLEND_ACC;
			ST_T_BFIN:    cmd.op = OP_BLEND_FIN;
			ST_RESULT:    cmd.op = res_go ? OP_RESULT : OP_NONE;
			default:      cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces one that leaves in the same cycle.
			if (res_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					axis_q <= 2'd0;
					if (in_valid)
						state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					unique case (stat.item_cmd)
						CMD_RECV: state_q <= ST_R_SNAP;
						CMD_TICK: state_q <= ST_T_PRE;
						default:  state_q <= ST_RESULT;
					endcase
				end
				ST_R_SNAP: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_R_SS;
					end else
						axis_q <= axis_q + 2'd1;
				end
				ST_R_SS:     state_q <= ST_R_COMMIT;
				ST_R_COMMIT: state_q <= ST_RESULT;
				ST_T_PRE: begin
					if (stat.teleport)
						state_q <= ST_RESULT;
					else if (stat.updated)
						state_q <= ST_T_DIVINIT;
					else
						state_q <= ST_T_REV;
				end
				ST_T_DIVINIT: state_q <= ST_T_DIV;
				ST_T_DIV: begin
					if (stat.div_done)
						state_q <= ST_T_VEL;
				end
				ST_T_VEL: state_q <= ST_T_REV;
				ST_T_REV: begin
					axis_q  <= 2'd0;
					state_q <= ST_T_AIM_MUL;
				end
				ST_T_AIM_MUL: state_q <= ST_T_AIM_ADD;
				ST_T_AIM_ADD: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_T_SNAP;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_T_AIM_MUL;
					end
				end
				ST_T_SNAP: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_T_SS;
					end else
						axis_q <= axis_q + 2'd1;
				end
				ST_T_SS: state_q <= ST_T_DECIDE;
				ST_T_DECIDE: begin
					axis_q  <= 2'd0;
					state_q <= stat.snap_res ? ST_RESULT : ST_T_BMUL;
				end
				ST_T_BMUL: state_q <= ST_T_BACC;
				ST_T_BACC: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_T_BFIN;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_T_BMUL;
					end
				end
				ST_T_BFIN: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (res_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/drs_dp.sv
// ----------------------------------------------------------------------------
// drs_dp
// Track state, configuration registers and the shared arithmetic of the
// smoother: snap-distance test, three-lane divider, aim and blend.
// ----------------------------------------------------------------------------
module drs_dp #(
	parameter int POS_WIDTH = drs_pkg::POS_WIDTH_DEF,
	parameter int FRAC_BITS = drs_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  drs_pkg::dp_cmd_t                 cmd,
	output drs_pkg::dp_stat_t                stat,
	input  logic                             cfg_we,
	input  logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [drs_pkg::CMD_W-1:0]        in_command,
	input  logic signed [POS_WIDTH-1:0]      in_pos [3],
	input  logic signed [POS_WIDTH-1:0]      in_body [3],
	output logic signed [POS_WIDTH-1:0]      res_body [3],
	output logic                             res_snapped,
	output logic                             res_predicting,
	output logic [drs_pkg::HOR_W-1:0]        res_horizon,
	output logic [drs_pkg::REV_W-1:0]        res_reverts
);
	import drs_pkg::*;

	localparam int P    = POS_WIDTH;
	localparam int DW   = P + 1;
	localparam int VW   = P + 1;
	localparam int BW   = VW + 10;
	localparam int PW   = VW + 11;
	localparam int CNTW = $clog2(DW + 1);
	localparam int MW   = (DW > SNAP_W) ? DW : SNAP_W;
	localparam int CW   = (DW > SPEED_W) ? DW : SPEED_W;
	localparam int SQW  = 2 * SNAP_W;
	localparam int SUMW = SQW + 2;
	localparam logic [BW-1:0] ARR_TH = BW'(1) << (FRAC_BITS - 4);

	// Configuration.
	logic [SPEED_W-1:0] max_speed_q;
	logic [SNAP_W-1:0]  snap_q;
	logic [HOR_W-1:0]   max_hor_q;
	logic [BLEND_W-1:0] blend_q;
	logic [IVL_W-1:0]   start_ivl_q;

	// Track state.
	logic signed [P-1:0]  conf_q [3];
	logic signed [P-1:0]  samp_q [3];
	logic signed [VW-1:0] vel_q  [3];
	logic [TICK_W-1:0]    ticks_q;
	logic [IVL_W-1:0]     avg_q;
	logic                 tele_q;
	logic                 upd_q;
	logic [REV_W-1:0]     rev_q;

	// Per-item work registers.
	item_cmd_t            item_cmd_q;
	logic signed [P-1:0]  pos_q  [3];
	logic signed [P-1:0]  body_q [3];
	logic signed [P-1:0]  aim_q  [3];
	logic signed [P-1:0]  step_q [3];
	logic signed [PW-1:0] prod_q;
	logic signed [BW-1:0] bm1_q;
	logic signed [BW-1:0] bm2_q;
	logic                 over_q;
	logic [SUMW-1:0]      sum_q;
	logic                 snap_res_q;
	logic                 arr_q;
	logic                 snapped_q;
	logic [DW-1:0]        dnd_q [3];
	logic [7:0]           rem_q [3];
	logic                 neg_q [3];
	logic [7:0]           divisor_q;
	logic [CNTW-1:0]      dcnt_q;

	function automatic logic signed [P-1:0] sat_pos(input logic signed [PW-1:0] v);
		logic [PW-P:0] top;
		top = v[PW-1:P-1];
		if ((&top) || !(|top))
			return v[P-1:0];
		else if (v[PW-1])
			return {1'b1, {(P-1){1'b0}}};
		else
			return {1'b0, {(P-1){1'b1}}};
	endfunction

	// Horizon and usual interval, from the averaged report interval.
	logic [IVL_W:0]     rnd_sum;
	logic [3:0]         rnd;
	logic [3:0]         rnd_p1;
	logic [HOR_W-1:0]   hor_lim;
	logic [HOR_W-1:0]   hor;
	logic [3:0]         usual;
	logic               moving;
	logic               in_hor;

	assign rnd_sum = {1'b0, avg_q} + (IVL_W + 1)'(128);
	assign rnd     = rnd_sum[IVL_W:8];
	assign rnd_p1  = rnd + 4'd1;
	assign hor_lim = ({4'b0, rnd_p1} > max_hor_q) ? max_hor_q : {4'b0, rnd_p1};
	assign hor     = (hor_lim < 8'd2) ? 8'd2 : hor_lim;
	assign usual   = (rnd == 4'd0) ? 4'd1 : rnd;
	assign moving  = (vel_q[0] != '0) || (vel_q[1] != '0) || (vel_q[2] != '0);
	assign in_hor  = ticks_q < hor;

	// Snap-distance term for one axis.
	logic signed [P-1:0]  sa, sb;
	logic signed [DW-1:0] sd;
	logic [DW-1:0]        smag;
	logic                 sover;
	logic [SNAP_W-1:0]    sclip;
	logic [SQW-1:0]       ssq;
	logic [SQW-1:0]       sss;

	assign sa    = cmd.sel_tick ? aim_q[cmd.axis]  : pos_q[cmd.axis];
	assign sb    = cmd.sel_tick ? body_q[cmd.axis] : conf_q[cmd.axis];
	assign sd    = $signed({sa[P-1], sa}) - $signed({sb[P-1], sb});
	assign smag  = sd[DW-1] ? DW'(-sd) : DW'(sd);
	assign sover = MW'(smag) > MW'(snap_q);
	assign sclip = sover ? snap_q : SNAP_W'(MW'(smag));
	assign ssq   = sclip * sclip;
	assign sss   = snap_q * snap_q;

	// Aim for one axis.
	logic [8:0]           lead;
	logic signed [BW-1:0] aim_prod;
	logic signed [PW-1:0] aim_sum;

	assign lead     = {1'b0, ticks_q} + 9'd1;
	assign aim_prod = vel_q[cmd.axis] * $signed({1'b0, lead});
	assign aim_sum  = PW'(conf_q[cmd.axis]) + prod_q;

	// Blend for one axis.
	logic [BLEND_W-1:0]   k;
	logic [BLEND_W-1:0]   inv_k;
	logic signed [VW-1:0] gap;
	logic signed [BW-1:0] b1, b2;
	logic [BW-1:0]        b1_mag;
	logic signed [PW-1:0] bsum;

	assign k      = (blend_q > 9'd256) ? 9'd256 : blend_q;
	assign inv_k  = 9'd256 - k;
	assign gap    = $signed({aim_q[cmd.axis][P-1], aim_q[cmd.axis]})
		- $signed({body_q[cmd.axis][P-1], body_q[cmd.axis]});
	assign b1     = gap * $signed({1'b0, inv_k});
	assign b2     = gap * $signed({1'b0, k}) + BW'(128);
	assign b1_mag = bm1_q[BW-1] ? BW'(-bm1_q) : BW'(bm1_q);
	assign bsum   = PW'(body_q[cmd.axis]) + PW'(bm2_q >>> 8);

	// Divider lanes: one restoring step per cycle on each axis.
	logic [8:0]           trial   [3];
	logic                 qbit    [3];
	logic signed [DW-1:0] ddiff   [3];
	logic [VW-1:0]        vmag    [3];
	logic [7:0]           div_sel;

	assign div_sel = (ticks_q <= hor) ? ticks_q : {4'b0, usual};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], dnd_q[i][DW-1]};
			qbit[i]  = trial[i] >= {1'b0, divisor_q};
			ddiff[i] = $signed({conf_q[i][P-1], conf_q[i]}) - $signed({samp_q[i][P-1], samp_q[i]});
			vmag[i]  = (CW'(dnd_q[i]) > CW'(max_speed_q)) ? VW'(CW'(max_speed_q))
				: VW'(dnd_q[i]);
		end
	end

	// Interval update.
	logic [IVL_W-1:0]        seen;
	logic signed [IVL_W+1:0] ivl_diff;
	logic signed [IVL_W+1:0] ivl_next;

	assign seen     = (ticks_q < 8'd4) ? {1'b0, ticks_q[1:0], 8'd0} : IVL_W'(1024);
	assign ivl_diff = $signed({2'b0, seen}) - $signed({2'b0, avg_q});
	assign ivl_next = $signed({2'b0, avg_q}) + (ivl_diff >>> 2);

	assign stat.item_cmd = item_cmd_q;
	assign stat.teleport = tele_q;
	assign stat.updated  = upd_q;
	assign stat.snap_res = snap_res_q;
	assign stat.div_done = (dcnt_q == CNTW'(DW));

	// Configuration and track state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			snap_q      <= SNAP_DIST_RST;
			max_hor_q   <= MAX_HOR_RST;
			blend_q     <= BLEND_RST;
			start_ivl_q <= START_IVL_RST;
			for (int i = 0; i < 3; i++) begin
				conf_q[i] <= '0;
				samp_q[i] <= '0;
				vel_q[i]  <= '0;
			end
			ticks_q <= '0;
			avg_q   <= START_IVL_RST;
			tele_q  <= 1'b0;
			upd_q   <= 1'b0;
			rev_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_SPEED:      max_speed_q <= cfg_data[SPEED_W-1:0];
					REG_SNAP_DISTANCE:  snap_q      <= cfg_data[SNAP_W-1:0];
					REG_MAX_HORIZON:    max_hor_q   <= cfg_data[HOR_W-1:0];
					REG_BLEND_FACTOR:   blend_q     <= cfg_data[BLEND_W-1:0];
					REG_START_INTERVAL: start_ivl_q <= cfg_data[IVL_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_PLACE: begin
					for (int i = 0; i < 3; i++) begin
						conf_q[i] <= pos_q[i];
						samp_q[i] <= pos_q[i];
						vel_q[i]  <= '0;
					end
					ticks_q <= '0;
					avg_q   <= start_ivl_q;
					tele_q  <= 1'b0;
					upd_q   <= 1'b0;
					rev_q   <= '0;
				end
				OP_RECV_COMMIT: begin
					if (snap_res_q)
						tele_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						conf_q[i] <= pos_q[i];
					upd_q <= 1'b1;
				end
				OP_TICK_PRE: begin
					if (tele_q) begin
						tele_q  <= 1'b0;
						upd_q   <= 1'b0;
						ticks_q <= '0;
						for (int i = 0; i < 3; i++) begin
							vel_q[i]  <= '0;
							samp_q[i] <= conf_q[i];
						end
					end else if (ticks_q != 8'hFF)
						ticks_q <= ticks_q + 8'd1;
				end
				OP_VEL_COMMIT: begin
					for (int i = 0; i < 3; i++) begin
						vel_q[i]  <= neg_q[i] ? $signed(-vmag[i]) : $signed(vmag[i]);
						samp_q[i] <= conf_q[i];
					end
					avg_q   <= ivl_next[IVL_W-1:0];
					ticks_q <= '0;
					upd_q   <= 1'b0;
				end
				OP_REVERT: begin
					if (!in_hor && moving) begin
						for (int i = 0; i < 3; i++)
							vel_q[i] <= '0;
						rev_q <= rev_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Item and work registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				item_cmd_q <= item_cmd_t'(in_command);
				snapped_q  <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					pos_q[i]  <= in_pos[i];
					body_q[i] <= in_body[i];
				end
			end
			OP_SNAP: begin
				if (cmd.axis == 2'd0) begin
					over_q <= sover;
					sum_q  <= SUMW'(ssq);
				end else begin
					over_q <= over_q | sover;
					sum_q  <= sum_q + SUMW'(ssq);
				end
			end
			OP_SNAP_SS: snap_res_q <= over_q || (sum_q > SUMW'(sss));
			OP_TICK_PRE: begin
				if (tele_q) begin
					snapped_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						body_q[i] <= conf_q[i];
				end
			end
			OP_DIV_INIT: begin
				divisor_q <= div_sel;
				dcnt_q    <= '0;
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= ddiff[i][DW-1];
					dnd_q[i] <= ddiff[i][DW-1] ? DW'(-ddiff[i]) : DW'(ddiff[i]);
					rem_q[i] <= '0;
				end
			end
			OP_DIV_STEP: begin
				dcnt_q <= dcnt_q + CNTW'(1);
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= qbit[i] ? 8'(trial[i] - {1'b0, divisor_q}) : trial[i][7:0];
					dnd_q[i] <= {dnd_q[i][DW-2:0], qbit[i]};
				end
			end
			OP_AIM_MUL: prod_q <= PW'(aim_prod);
			OP_AIM_ADD: aim_q[cmd.axis] <= in_hor ? sat_pos(aim_sum) : conf_q[cmd.axis];
			OP_SNAP_APPLY: begin
				arr_q <= 1'b1;
				if (snap_res_q) begin
					snapped_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						body_q[i] <= aim_q[i];
				end
			end
			OP_BLEND_MUL: begin
				bm1_q <= b1;
				bm2_q <= b2;
			end
			OP_BLEND_ACC: begin
				if (b1_mag >= ARR_TH)
					arr_q <= 1'b0;
				step_q[cmd.axis] <= sat_pos(bsum);
			end
			OP_BLEND_FIN: begin
				for (int i = 0; i < 3; i++)
					body_q[i] <= arr_q ? aim_q[i] : step_q[i];
			end
			OP_RESULT: begin
				for (int i = 0; i < 3; i++)
					res_body[i] <= body_q[i];
				res_snapped    <= snapped_q;
				res_predicting <= in_hor && moving;
				res_horizon    <= hor;
				res_reverts    <= rev_q;
			end
			default: ;
		endcase
	end

endmodule

### design/dead_reckoning_smoother_unit.sv
// ----------------------------------------------------------------------------
// dead_reckoning_smoother_unit
// Dead-reckoning smoother for a 3D body fed by sparse position reports.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries a command on s_tuser (place, receive or
// tick) and the reported position and displayed body on s_tdata. Every input
// transfer yields exactly one output transfer on m_tdata with the new body,
// the snapped and predicting flags, the horizon and the revert count.
// Configuration registers are written on the cfg channel, which is always
// ready; writes belong to times when no item is in flight.
// A place or an unused command goes straight to its result, a receive runs
// the snap-distance test, a tick that teleports skips the prediction, and a
// full tick also updates the velocity. The velocity update dominates: it
// runs a three-lane restoring divider, one quotient bit per cycle, and the
// aim and blend steps reuse their multipliers for each axis in turn. Items
// are processed one at a time: the block accepts no new item until the
// current one has reached its result stage.
// The result sits in an output register; the block takes the next item while
// it waits, and finishes that item's work but holds its result until the
// receiver takes the previous one. Reset clears the track, loads the default
// configuration and leaves no result pending.
// ----------------------------------------------------------------------------
module dead_reckoning_smoother_unit #(
	parameter int POS_WIDTH = drs_pkg::POS_WIDTH_DEF,
	parameter int FRAC_BITS = drs_pkg::FRAC_BITS_DEF,
	parameter int IN_W  = ((6 * POS_WIDTH + 7) / 8) * 8,
	parameter int OUT_W = ((3 * POS_WIDTH + 26 + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, body_x, body_y, body_z from bit 0 up
	input  logic [IN_W-1:0]                 s_tdata,
	// command
	input  logic [drs_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// new_body_x, new_body_y, new_body_z, snapped, is_predicting,
	// horizon_ticks, revert_count from bit 0 up
	output logic [OUT_W-1:0]                m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [drs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import drs_pkg::*;

	localparam int P = POS_WIDTH;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic signed [P-1:0] in_pos  [3];
	logic signed [P-1:0] in_body [3];
	logic signed [P-1:0] res_body [3];
	logic              res_snapped;
	logic              res_predicting;
	logic [HOR_W-1:0]  res_horizon;
	logic [REV_W-1:0]  res_reverts;

	// Configuration writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i]  = s_tdata[i*P +: P];
			in_body[i] = s_tdata[(i+3)*P +: P];
		end
	end

	assign m_tdata = OUT_W'({res_reverts, res_horizon, res_predicting, res_snapped,
		res_body[2], res_body[1], res_body[0]});

	drs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	drs_dp #(
		.POS_WIDTH (POS_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_command     (s_tuser),
		.in_pos         (in_pos),
		.in_body        (in_body),
		.res_body       (res_body),
		.res_snapped    (res_snapped),
		.res_predicting (res_predicting),
		.res_horizon    (res_horizon),
		.res_reverts    (res_reverts)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dead reckoning smoother.
// ----------------------------------------------------------------------------
// Items are sent on the input stream and results are taken from the output
// stream. Both sides stall in random bursts. A behavioral tracker in this
// bench computes the expected body, flags, horizon and revert count of every
// accepted item, and each output transfer is compared field by field with the
// oldest pending expectation. The run first walks a short stimulus table and
// then sends random track sequences: places, report bursts and tick runs.
// The configuration registers are rewritten between phases, extremes
// included, while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
	import drs_pkg::*;

	localparam int PW    = 32;
	localparam int IN_W  = 192;
	localparam int OUT_W = 128;

	typedef struct packed {
		logic [15:0]       reverts;
		logic [7:0]        horizon;
		logic              predicting;
		logic              snapped;
		logic signed [PW-1:0] bz;
		logic signed [PW-1:0] by;
		logic signed [PW-1:0] bx;
	} smooth_res_t;

	typedef struct {
		item_cmd_t cmd;
		logic signed [PW-1:0] p [3];
		logic signed [PW-1:0] b [3];
		bit has_exp;
		smooth_res_t exp_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dead_reckoning_smoother_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// Tracker state: a copy of the block's configuration and track registers.
	// Wide signed arithmetic is used so that no intermediate can overflow.
	// ---------------------------------------------------------------------------
	logic [23:0] cf_speed;
	logic [19:0] cf_snap;
	logic [7:0]  cf_hor;
	logic [8:0]  cf_blend;
	logic [10:0] cf_start;

	longint trk_conf [3];
	longint trk_samp [3];
	longint trk_vel [3];
	int unsigned trk_ticks, trk_avg, trk_rev;
	bit trk_teleport, trk_updated;

	smooth_res_t body_q [$];
	int errors = 0;
	bit no_idle = 1'b0;
	bit out_stall_on = 1'b1;

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	function automatic longint sat_pos(longint v);
		return v > POS_MAX ? POS_MAX : (v < POS_MIN ? POS_MIN : v);
	endfunction

	// Floor division by 2**s for signed values; >>> on longint already floors.
	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Strict distance test with exact squared sums; an axis beyond the limit
	// short-circuits so the square sum never overflows.
	function automatic bit past_snap(longint a [3], longint b [3]);
		longint unsigned s, sum, d;
		s = cf_snap;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = abs_l(a[i] - b[i]);
			if (d > s) return 1'b1;
			sum += d * d;
		end
		return sum > s * s;
	endfunction

	function automatic int unsigned horizon_of();
		int unsigned t;
		t = ((trk_avg + 128) >> 8) + 1;
		if (t > cf_hor) t = cf_hor;
		return t < 2 ? 2 : t;
	endfunction

	function automatic bit in_motion();
		return trk_vel[0] != 0 || trk_vel[1] != 0 || trk_vel[2] != 0;
	endfunction

	task automatic clear_track();
		for (int i = 0; i < 3; i++) begin
			trk_conf[i] = 0;
			trk_samp[i] = 0;
			trk_vel[i] = 0;
		end
		trk_ticks = 0;
		trk_avg = cf_start;
		trk_teleport = 0;
		trk_updated = 0;
		trk_rev = 0;
	endtask

	task automatic tick_body(inout longint body [3], output bit snapped);
		longint aim [3];
		longint k, lim, tk, v, seen, diff, lead;
		int unsigned usual;
		bit arrived;
		k = cf_blend > 256 ? 256 : cf_blend;
		arrived = 1'b1;
		snapped = 1'b0;
		if (trk_ticks < 255) trk_ticks++;
		if (trk_teleport) begin
			trk_teleport = 0;
			trk_updated = 0;
			for (int i = 0; i < 3; i++) begin
				trk_vel[i] = 0;
				trk_samp[i] = trk_conf[i];
				body[i] = trk_conf[i];
			end
			trk_ticks = 0;
			snapped = 1'b1;
			return;
		end
		if (trk_updated) begin
			usual = (trk_avg + 128) >> 8;
			if (usual < 1) usual = 1;
			tk = trk_ticks <= horizon_of() ? trk_ticks : usual;
			lim = cf_speed;
			for (int i = 0; i < 3; i++) begin
				v = (trk_conf[i] - trk_samp[i]) / tk;
				trk_vel[i] = v > lim ? lim : (v < -lim ? -lim : v);
				trk_samp[i] = trk_conf[i];
			end
			seen = (trk_ticks < 4 ? trk_ticks : 4) * 256;
			diff = seen - longint'(trk_avg);
			trk_avg = int'(longint'(trk_avg) + floor_sh(diff, 2)) & 32'h7FF;
			trk_ticks = 0;
			trk_updated = 0;
		end
		for (int i = 0; i < 3; i++) aim[i] = trk_conf[i];
		if (trk_ticks < horizon_of()) begin
			lead = longint'(trk_ticks) + 1;
			for (int i = 0; i < 3; i++) aim[i] = sat_pos(trk_conf[i] + trk_vel[i] * lead);
		end else if (in_motion()) begin
			for (int i = 0; i < 3; i++) trk_vel[i] = 0;
			trk_rev = (trk_rev + 1) & 16'hFFFF;
		end
		if (past_snap(aim, body)) begin
			for (int i = 0; i < 3; i++) body[i] = aim[i];
			snapped = 1'b1;
			return;
		end
		for (int i = 0; i < 3; i++)
			if (abs_l((aim[i] - body[i]) * (256 - k)) >= 256) arrived = 1'b0;
		for (int i = 0; i < 3; i++)
			body[i] = arrived ? aim[i]
				: sat_pos(body[i] + floor_sh((aim[i] - body[i]) * k + 128, 8));
	endtask

	// Applies one accepted item to the tracker and returns its result.
	task automatic track_item(input stim_row_t r, output smooth_res_t res);
		longint pos [3], body [3];
		bit snapped;
		snapped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pos[i] = r.p[i];
			body[i] = r.b[i];
		end
		case (r.cmd)
			CMD_PLACE: begin
				clear_track();
				for (int i = 0; i < 3; i++) begin
					trk_conf[i] = pos[i];
					trk_samp[i] = pos[i];
				end
			end
			CMD_RECV: begin
				if (past_snap(pos, trk_conf)) trk_teleport = 1;
				for (int i = 0; i < 3; i++) trk_conf[i] = pos[i];
				trk_updated = 1;
			end
			CMD_TICK: tick_body(body, snapped);
			default: ;
		endcase
		res.bx = body[0][PW-1:0];
		res.by = body[1][PW-1:0];
		res.bz = body[2][PW-1:0];
		res.snapped = snapped;
		res.predicting = trk_ticks < horizon_of() && in_motion();
		res.horizon = horizon_of();
		res.reverts = trk_rev[15:0];
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// ---------------------------------------------------------------------------
	// Output side: random stalls and checking of every output transfer.
	// ---------------------------------------------------------------------------
	initial begin
		int idle;
		smooth_res_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = smooth_res_t'(m_tdata[121:0]);
				if (body_q.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 0);
				end else begin
					want = body_q.pop_front();
					if (got.bx !== want.bx) report_mismatch("new_body_x", got.bx, want.bx);
					if (got.by !== want.by) report_mismatch("new_body_y", got.by, want.by);
					if (got.bz !== want.bz) report_mismatch("new_body_z", got.bz, want.bz);
					if (got.snapped !== want.snapped)
						report_mismatch("snapped", got.snapped, want.snapped);
					if (got.predicting !== want.predicting)
						report_mismatch("is_predicting", got.predicting, want.predicting);
					if (got.horizon !== want.horizon)
						report_mismatch("horizon_ticks", got.horizon, want.horizon);
					if (got.reverts !== want.reverts)
						report_mismatch("revert_count", got.reverts, want.reverts);
				end
			end
			if (idle > 0) begin
				idle--;
				m_tready <= 1'b0;
			end else if (!no_idle && out_stall_on && $urandom_range(0, 9) == 0) begin
				idle = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Input side. Valid stays high from one item to the next unless an idle
	// burst or a drain drops it.
	// ---------------------------------------------------------------------------
	task automatic send_item(input stim_row_t r);
		smooth_res_t res;
		int gap;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {r.b[2], r.b[1], r.b[0], r.p[2], r.p[1], r.p[0]};
		do @(posedge clk); while (!s_tready);
		track_item(r, res);
		if (r.has_exp && res !== r.exp_res)
			report_mismatch("tracker against table", res, r.exp_res);
		body_q.push_back(res);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (body_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_SPEED:     cf_speed = val[23:0];
			REG_SNAP_DISTANCE: cf_snap = val[19:0];
			REG_MAX_HORIZON:   cf_hor = val[7:0];
			REG_BLEND_FACTOR:  cf_blend = val[8:0];
			default:           cf_start = val[10:0];
		endcase
	endtask

	function automatic logic signed [PW-1:0] rand_pos(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 65535)) - 32768;
			default: return $signed($urandom_range(0, 4096 * 8)) - 4096 * 4;
		endcase
	endfunction

	function automatic stim_row_t mk_row(item_cmd_t c, int mode);
		stim_row_t r;
		r.cmd = c;
		r.has_exp = 1'b0;
		r.exp_res = '0;
		for (int i = 0; i < 3; i++) begin
			r.p[i] = rand_pos(mode);
			r.b[i] = rand_pos(mode);
		end
		return r;
	endfunction

	function automatic stim_row_t fixed_row(item_cmd_t c, longint pv, longint bv);
		stim_row_t r;
		r.cmd = c;
		r.has_exp = 1'b0;
		r.exp_res = '0;
		for (int i = 0; i < 3; i++) begin
			r.p[i] = pv[PW-1:0];
			r.b[i] = bv[PW-1:0];
		end
		return r;
	endfunction

	// A report near the current track so that blending and prediction happen.
	function automatic stim_row_t near_report(int spread);
		stim_row_t r;
		r = mk_row(CMD_RECV, 2);
		for (int i = 0; i < 3; i++)
			r.p[i] = sat_pos(trk_conf[i] + $signed($urandom_range(0, 2 * spread)) - spread);
		return r;
	endfunction

	task automatic random_phase(int n);
		stim_row_t r;
		int left, mode, spread;
		longint body [3];
		left = n;
		for (int i = 0; i < 3; i++) body[i] = 0;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				// Noise: any command, any values.
				r = mk_row(item_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 2));
				send_item(r);
				left--;
				continue;
			end
			mode = $urandom_range(1, 2);
			r = mk_row(CMD_PLACE, mode);
			send_item(r);
			left--;
			for (int i = 0; i < 3; i++) body[i] = trk_conf[i];
			spread = $urandom_range(0, 3) == 0 ? 40000 : $urandom_range(0, 9000);
			repeat ($urandom_range(2, 8)) begin
				if (left <= 0) break;
				r = near_report(spread);
				send_item(r);
				left--;
				repeat ($urandom_range(1, 12)) begin
					if (left <= 0) break;
					r = mk_row(CMD_TICK, 2);
					// Mostly feed the displayed body back in, as a user would.
					if ($urandom_range(0, 4) != 0)
						for (int i = 0; i < 3; i++) r.b[i] = body[i][PW-1:0];
					send_item(r);
					left--;
					for (int i = 0; i < 3; i++) body[i] = body_q[$].bx;
					body[1] = body_q[$].by;
					body[2] = body_q[$].bz;
				end
			end
		end
	endtask

	initial begin
		stim_row_t dir_tab [$];
		stim_row_t r;
		cf_speed = MAX_SPEED_RST;
		cf_snap = SNAP_DIST_RST;
		cf_hor = MAX_HOR_RST;
		cf_blend = BLEND_RST;
		cf_start = START_IVL_RST;
		clear_track();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Rows with a typed expectation follow directly from
		// the reset state; the others rely on the tracker.
		r = fixed_row(CMD_NOP, 123, -77);
		r.has_exp = 1'b1;
		r.exp_res = '{reverts: 0, horizon: 2, predicting: 0, snapped: 0,
			bz: -77, by: -77, bx: -77};
		dir_tab.push_back(r);
		r = fixed_row(CMD_TICK, 0, 0);
		r.has_exp = 1'b1;
		r.exp_res = '{reverts: 0, horizon: 2, predicting: 0, snapped: 0,
			bz: 0, by: 0, bx: 0};
		dir_tab.push_back(r);
		r = fixed_row(CMD_PLACE, POS_MAX, POS_MIN);
		r.has_exp = 1'b1;
		r.exp_res = '{reverts: 0, horizon: 2, predicting: 0, snapped: 0,
			bz: POS_MIN, by: POS_MIN, bx: POS_MIN};
		dir_tab.push_back(r);
		dir_tab.push_back(fixed_row(CMD_TICK, 0, POS_MIN));
		dir_tab.push_back(fixed_row(CMD_RECV, POS_MIN, 0));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 5));
		dir_tab.push_back(fixed_row(CMD_PLACE, 0, 0));
		dir_tab.push_back(fixed_row(CMD_RECV, 4096, 0));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 0));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 100));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 4096));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 4096));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 4096));
		dir_tab.push_back(fixed_row(CMD_RECV, 40000, 0));
		dir_tab.push_back(fixed_row(CMD_RECV, 9000, 0));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 8000));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, 8001));
		dir_tab.push_back(fixed_row(CMD_PLACE, POS_MAX - 10, POS_MAX));
		dir_tab.push_back(fixed_row(CMD_RECV, POS_MAX, 0));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, POS_MAX));
		dir_tab.push_back(fixed_row(CMD_TICK, 0, POS_MAX));
		dir_tab.push_back(fixed_row(CMD_NOP, POS_MIN, POS_MAX));
		foreach (dir_tab[i]) send_item(dir_tab[i]);
		wait_drain();

		random_phase(350);
		wait_drain();
		// Extremes: widest limits, full blend, longest horizon.
		write_reg(REG_MAX_SPEED, 24'hFFFFFF);
		write_reg(REG_SNAP_DISTANCE, 20'hFFFFF);
		write_reg(REG_MAX_HORIZON, 255);
		write_reg(REG_BLEND_FACTOR, 256);
		write_reg(REG_START_INTERVAL, 1024);
		random_phase(300);
		wait_drain();
		// Tightest limits: no speed, no snap distance, shortest horizon.
		write_reg(REG_MAX_SPEED, 0);
		write_reg(REG_SNAP_DISTANCE, 0);
		write_reg(REG_MAX_HORIZON, 0);
		write_reg(REG_BLEND_FACTOR, 0);
		write_reg(REG_START_INTERVAL, 0);
		random_phase(250);
		wait_drain();
		// Oversized blend factor and out-of-range start interval.
		write_reg(REG_MAX_SPEED, 300);
		write_reg(REG_SNAP_DISTANCE, 30000);
		write_reg(REG_MAX_HORIZON, 2);
		write_reg(REG_BLEND_FACTOR, 511);
		write_reg(REG_START_INTERVAL, 2047);
		random_phase(250);
		wait_drain();
		// Random middle settings.
		write_reg(REG_MAX_SPEED, $urandom_range(100, 20000));
		write_reg(REG_SNAP_DISTANCE, $urandom_range(2000, 60000));
		write_reg(REG_MAX_HORIZON, $urandom_range(3, 20));
		write_reg(REG_BLEND_FACTOR, $urandom_range(1, 255));
		write_reg(REG_START_INTERVAL, $urandom_range(1, 1023));
		random_phase(300);
		// Final stretch with no idling on either side.
		no_idle = 1'b1;
		random_phase(200);
		s_tvalid <= 1'b0;
		while (body_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("dead_reckoning_smoother_unit: match");
		end else begin
			$display("dead_reckoning_smoother_unit: mismatch");
		end
		$finish;
	end

	// Slowest run: about 1700 items with random stalls on both sides; it ends
	// within the 10 ms limit below.
	initial begin
		#10_000_000;
		$display("dead_reckoning_smoother_unit: mismatch");
		$finish;
	end

endmodule

### filelist.f
design/drs_pkg.sv
design/drs_ctrl.sv
design/drs_dp.sv
design/dead_reckoning_smoother_unit.sv
test/tb_top.sv
